/* sv/esort_pkg.sv */
// Shared types and constants for the exchange sort block.
`timescale 1ns / 1ps
`default_nettype none
package esort_pkg;

  // Capacity of the entry store
  localparam int unsigned MaxItems = 32;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned KeyW     = 31;
  localparam int unsigned TagW     = 16;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // Input item
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
    logic            last_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic [TagW-1:0] sorted_tag;
    logic            last_out;
  } out_item_t;

  // One stored entry
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  // Store access request from the sequencer
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_OUTER,
    ST_HOLD,
    ST_INNER,
    ST_WBACK,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

endpackage
`default_nettype wire

/* sv/esort_mem.sv */
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module esort_mem (
  input  logic              clk_i,
  input  esort_pkg::mem_req_t req_i,
  output esort_pkg::entry_t rdata_o
);
  import esort_pkg::*;

  entry_t mem_q [MaxItems];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/esort_ctrl.sv */
// Sequencer: loads entries, runs the compare-swap unit, streams the sorted set.
`timescale 1ns / 1ps
`default_nettype none
module esort_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  esort_pkg::in_item_t  in_item_i,
  output logic                 in_stall_o,
  output esort_pkg::mem_req_t  mem_req_o,
  input  esort_pkg::entry_t    mem_rdata_i,
  input  logic                 out_free_i,
  output logic                 out_load_o,
  output esort_pkg::out_item_t out_item_o
);
  import esort_pkg::*;

  state_e state_q, state_d;
  cnt_t   fill_q, fill_d;
  idx_t   i_q, i_d;
  idx_t   j_q, j_d;
  entry_t held_q, held_d;

  cnt_t   nxt_i;
  cnt_t   nxt_j;
  logic   full;
  logic   in_xfer;
  logic   swap;

  assign nxt_i   = cnt_t'(i_q) + cnt_t'(1);
  assign nxt_j   = cnt_t'(j_q) + cnt_t'(1);
  assign full    = (fill_q == cnt_t'(MaxItems));
  assign in_xfer = in_valid_i && (state_q == ST_LOAD);
  // Shared compare unit: held entry i against fetched entry j
  assign swap    = (held_q.key >= mem_rdata_i.key);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer && in_item_i.last_in) state_d = ST_OUTER;
      end
      ST_OUTER: state_d = ST_HOLD;
      ST_HOLD: begin
        state_d = (nxt_i == fill_q) ? ST_WBACK : ST_INNER;
      end
      ST_INNER: begin
        if (nxt_j == fill_q) state_d = ST_WBACK;
      end
      ST_WBACK: begin
        state_d = (nxt_i == fill_q) ? ST_EMIT_RD : ST_OUTER;
      end
      ST_EMIT_RD: state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_free_i) state_d = (nxt_i == fill_q) ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs: handshake, store requests, result load
  always_comb begin
    in_stall_o = 1'b1;
    mem_req_o  = '0;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i && !full) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = fill_q[IdxW-1:0];
          mem_req_o.wdata = '{key: in_item_i.key, tag: in_item_i.tag};
        end
      end
      ST_OUTER: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = i_q;
      end
      ST_HOLD: begin
        if (nxt_i != fill_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = nxt_i[IdxW-1:0];
        end
      end
      ST_INNER: begin
        // old held entry drops into slot j on a swap
        if (swap) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = j_q;
          mem_req_o.wdata = held_q;
        end
        if (nxt_j != fill_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = nxt_j[IdxW-1:0];
        end
      end
      ST_WBACK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = i_q;
        mem_req_o.wdata = held_q;
      end
      ST_EMIT_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = i_q;
      end
      ST_EMIT_WAIT: begin
        out_load_o = out_free_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign out_item_o = '{sorted_key: mem_rdata_i.key,
                        sorted_tag: mem_rdata_i.tag,
                        last_out:   (nxt_i == fill_q)};

  // Counters and held entry
  always_comb begin
    fill_d = fill_q;
    i_d    = i_q;
    j_d    = j_q;
    held_d = held_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer && !full) fill_d = fill_q + cnt_t'(1);
        if (in_xfer && in_item_i.last_in) i_d = '0;
      end
      ST_OUTER: ;
      ST_HOLD: begin
        held_d = mem_rdata_i;
        j_d    = nxt_i[IdxW-1:0];
      end
      ST_INNER: begin
        if (swap) held_d = mem_rdata_i;
        j_d = nxt_j[IdxW-1:0];
      end
      ST_WBACK: begin
        i_d = (nxt_i == fill_q) ? '0 : nxt_i[IdxW-1:0];
      end
      ST_EMIT_RD: ;
      ST_EMIT_WAIT: begin
        if (out_free_i) begin
          if (nxt_i == fill_q) begin
            i_d    = '0;
            fill_d = '0;
          end else begin
            i_d = nxt_i[IdxW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Held entry, payload only
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule
`default_nettype wire

/* sv/exchange_sort_keys_with_tags.sv */
// Top level of the exchange sort block: sequencer, entry store, result register.
//
// Usage: items (key, tag, last_in) arrive on the input channel (in_valid_i,
// in_stall_o). Each transfer stores one entry; once 32 entries are held,
// further items of the set are dropped. The transfer with last_in set starts
// the sort, and the input stalls until every sorted entry has been handed out.
// Results (sorted_key, sorted_tag, last_out) leave on the output channel
// (out_valid_o, out_stall_i) in ascending key order, last_out on the final one.
// Flow for a set of held entries: the input takes one item per cycle while
// loading; the sort runs the single compare-swap unit, once per cycle in its
// inner loop, against the store with one write port and one read port;
// emission reads each result from the store, then loads it into the result
// register, one result at a time.
// A stall on the output holds the result register; the sequencer waits.
// Reset empties the set and clears the output valid; store contents are
// not cleared and are never read before being written within a set.
`timescale 1ns / 1ps
`default_nettype none
module exchange_sort_keys_with_tags (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  esort_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output esort_pkg::out_item_t out_item_o
);
  import esort_pkg::*;

  mem_req_t  mem_req;
  entry_t    mem_rdata;
  logic      out_free;
  logic      out_load;
  out_item_t out_next;
  logic      out_valid_q;
  out_item_t out_item_q;

  esort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_item_o  (out_next)
  );

  esort_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Result register frees up when empty or when its transfer completes
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

/* sv/esort_chk.sv */
// Port-level checks for the exchange sort block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module esort_chk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  esort_pkg::in_item_t  in_item_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  esort_pkg::out_item_t out_item_o
);

  // A stalled result stays valid and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

  // The last item of a set closes the input while sorting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.last_in |=> in_stall_o)
    else $error("input not stalled after last item");

  // New results appear only while the input is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while loading");

  // The input closes only after an offered item with last_in set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i) && $past(in_item_i.last_in))
    else $error("input stalled without a last item");

endmodule

bind exchange_sort_keys_with_tags esort_chk u_esort_chk (.*);
`default_nettype wire

/* verif/exchange_sort_keys_with_tags_tb.sv */
// Self-checking testbench for the exchange sort block with key/tag entries.
`timescale 1ns / 1ps
module exchange_sort_keys_with_tags_tb;
  import esort_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 7;
  localparam int HoldCycles    = 1500;
  localparam int DrainCycles   = 64;
  localparam int RandomItems   = 160;
  localparam int ReportLimit   = 10;
  // ~30 sets of up to 32 entries with their sorts and stalled emission,
  // ~300 items with sender gaps, one long hold-off, then margin on top
  localparam int TimeoutCycles = 400000;

  localparam logic [KeyW-1:0] KeyMax = '1;
  localparam logic [TagW-1:0] TagMax = '1;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_STROBE
  } rx_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Predictor state: entries of the open set, sorted results still owed
  entry_t    held_entries[$];
  out_item_t sorted_q[$];

  int        burst_left    = 0;
  int        error_count   = 0;
  int        items_sent    = 0;
  int        dropped_count = 0;
  int        sets_done     = 0;
  int        results_seen  = 0;

  bit        hold_start  = 1'b0;
  logic      hold_active = 1'b0;
  rx_mode_e  rx_mode     = RX_OPEN;
  int        rx_dwell    = 0;
  int        rx_tick     = 0;

  exchange_sort_keys_with_tags u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  // Predictor: store the entry, and on the last one sort and queue the results
  function automatic void accept_item(in_item_t item);
    entry_t    ent;
    entry_t    tmp;
    out_item_t res;
    items_sent++;
    ent.key = item.key;
    ent.tag = item.tag;
    if (held_entries.size() < MaxItems) held_entries = {held_entries, ent};
    else dropped_count++;
    if (item.last_in) begin
      // exchange sort: swap i and j whenever key[i] >= key[j], ties included
      for (int i = 0; i < held_entries.size(); i++) begin
        for (int j = i; j < held_entries.size(); j++) begin
          if (held_entries[i].key >= held_entries[j].key) begin
            tmp             = held_entries[i];
            held_entries[i] = held_entries[j];
            held_entries[j] = tmp;
          end
        end
      end
      for (int k = 0; k < held_entries.size(); k++) begin
        res.sorted_key = held_entries[k].key;
        res.sorted_tag = held_entries[k].tag;
        res.last_out   = (k == held_entries.size() - 1);
        sorted_q = {sorted_q, res};
      end
      held_entries.delete();
      sets_done++;
    end
  endfunction

  function automatic in_item_t mk_item(logic [KeyW-1:0] key, logic [TagW-1:0] tag,
                                       logic last);
    in_item_t it;
    it.key     = key;
    it.tag     = tag;
    it.last_in = last;
    return it;
  endfunction

  // One input transfer, then the sender's burst/gap bookkeeping
  task automatic send_item(in_item_t item);
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accept_item(item);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 5);
    end
  endtask

  // Set of n random entries; key spread picks full range, ties, or near the top
  task automatic send_random_set(int n);
    int          spread;
    logic [31:0] key;
    spread = $urandom_range(0, 2);
    for (int k = 0; k < n; k++) begin
      case (spread)
        0:       key = $urandom();
        1:       key = $urandom_range(0, 7);
        default: key = KeyMax - $urandom_range(0, 7);
      endcase
      send_item(mk_item(key[KeyW-1:0], TagW'($urandom()), k == n - 1));
    end
  endtask

  task automatic test_single_entry();
    send_item(mk_item(KeyMax, TagMax, 1'b1));
    send_item(mk_item('0, '0, 1'b1));
  endtask

  // Extreme keys mixed with equal keys; tags show the tie order
  task automatic test_extremes_and_ties();
    send_item(mk_item(KeyMax, 16'h0001, 1'b0));
    send_item(mk_item('0, 16'hAAAA, 1'b0));
    send_item(mk_item(31'd7, 16'h5555, 1'b0));
    send_item(mk_item(31'd7, TagMax, 1'b0));
    send_item(mk_item(KeyMax, 16'h0002, 1'b0));
    send_item(mk_item('0, '0, 1'b0));
    send_item(mk_item(31'd7, 16'h0003, 1'b1));
  endtask

  task automatic test_presorted_orders();
    for (int k = 1; k <= 5; k++) send_item(mk_item(KeyW'(k), TagW'(k), k == 5));
    for (int k = 5; k >= 1; k--) send_item(mk_item(KeyW'(k << 26), TagW'(k), k == 1));
  endtask

  // Sets past capacity, in each of which the last item itself is dropped
  task automatic test_store_full();
    send_random_set(MaxItems + 1);
    send_random_set(MaxItems + 4);
  endtask

  // Receiver holds off while a full set and the next one are offered
  task automatic test_pressure();
    hold_start = 1'b1;
    send_random_set(MaxItems + 8);
    send_random_set(5);
  endtask

  // Mostly small sets, a few near, at or beyond capacity
  task automatic test_random_sets();
    int sent;
    int n;
    sent = 0;
    while (sent < RandomItems) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(MaxItems - 4, MaxItems + 8)
                                      : $urandom_range(1, 10);
      send_random_set(n);
      sent += n;
    end
  endtask

  // Long receiver hold-off, counted here
  always begin : rx_hold_off
    wait (hold_start);
    hold_start = 1'b0;
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  // Receiver stall pattern: a mode held for a random dwell, then another
  always @(posedge clk_i) begin : rx_stall_gen
    logic pick;
    if (rx_dwell == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_dwell = $urandom_range(16, 120);
    end else begin
      rx_dwell--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  pick = 1'b0;
      RX_LIGHT: pick = ($urandom_range(0, 3) == 0);
      RX_HEAVY: pick = ($urandom_range(0, 3) != 0);
      default:  pick = (rx_tick % 4 != 0);
    endcase
    out_stall_i <= hold_active || pick;
  end

  // Result check against the oldest expected result
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("%0t: unexpected result key=%0h tag=%0h last=%b", $realtime,
                   out_item_o.sorted_key, out_item_o.sorted_tag, out_item_o.last_out);
      end else begin
        want = sorted_q.pop_front();
        if (out_item_o.sorted_key !== want.sorted_key ||
            out_item_o.sorted_tag !== want.sorted_tag ||
            out_item_o.last_out !== want.last_out) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("%0t: mismatch exp key=%0h tag=%0h last=%b got key=%0h tag=%0h last=%b",
                     $realtime, want.sorted_key, want.sorted_tag, want.last_out,
                     out_item_o.sorted_key, out_item_o.sorted_tag, out_item_o.last_out);
        end
      end
    end
  end

  initial begin : run_tests
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_entry();
    test_extremes_and_ties();
    test_presorted_orders();
    test_store_full();
    test_pressure();
    test_random_sets();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sorted %0d sets from %0d items (%0d dropped at a full store), %0d results",
             sets_done, items_sent, dropped_count, results_seen);
    $display("Receiver hold-off of %0d cycles applied once; %0d errors, %0d results owed",
             HoldCycles, error_count, sorted_q.size());
    if (error_count == 0 && sorted_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout with %0d results still owed", sorted_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
sv/esort_pkg.sv
sv/esort_mem.sv
sv/esort_ctrl.sv
sv/exchange_sort_keys_with_tags.sv
sv/esort_chk.sv
verif/exchange_sort_keys_with_tags_tb.sv
